// ===== rtl/ctd_pkg.sv =====
// ----------------------------------------------------------------------------
// Chirp tone package
// Shared widths, constants, opcodes and the quarter-wave sine generator used
// to build the sine table of the chirp tone block.
// ----------------------------------------------------------------------------
package ctd_pkg;

   // Default structural parameters of the top level.
   localparam int LENGTH_BITS_DEF     = 16;
   localparam int PHASE_BITS_DEF      = 32;
   localparam int SINE_TABLE_BITS_DEF = 10;

   // Fixed field widths.
   localparam int FREQ_W   = 20;
   localparam int LEN_W    = 16;
   localparam int VOL_W    = 16;
   localparam int SAMPLE_W = 16;
   localparam int RATE_W   = 17;

   localparam logic [RATE_W-1:0] RATE_RESET = 17'd44100;

   // Frequencies carry four fraction bits (hertz times 16).
   localparam int FREQ_FRAC = 4;

   // The envelope is a 16-bit fraction that can reach exactly one.
   localparam int ENV_FRAC = 16;
   localparam int ENV_W    = 17;

   // Sine table magnitude, Q0.15.
   localparam int SINE_MAG_W = 15;

   // Output scale and the final right shift of the amplitude product.
   localparam logic [14:0] FULL_SCALE  = 15'd32000;
   localparam int          SCALE_SHIFT = 46;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   // Request opcodes.
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam longint Q30 = 64'sd1073741824;
   localparam longint Q29 = 64'sd536870912;

   // Quarter-wave sine magnitude for x, a Q14 fraction of a quarter turn
   // (0 to 16384). Evaluated at elaboration only, to fill the sine table.
   function automatic logic [SINE_MAG_W-1:0] sine_quarter(input longint x);
      longint x2;
      longint p;
      longint y;
      x2 = (x * x) * 4;
      p  = 64'sd172272;
      p  = -64'sd5026995 + (p * x2) / Q30;
      p  = 64'sd85569306 + (p * x2) / Q30;
      p  = -64'sd693598669 + (p * x2) / Q30;
      p  = 64'sd1686629713 + (p * x2) / Q30;
      y  = (p * x) / Q29;
      if (y > 64'sd32767) begin
         y = 64'sd32767;
      end
      if (y < 64'sd0) begin
         y = 64'sd0;
      end
      return SINE_MAG_W'(y);
   endfunction

endpackage

// ===== rtl/ctd_div.sv =====
// ----------------------------------------------------------------------------
// Chirp tone divider
// Restoring unsigned divider that produces one quotient bit per cycle. The
// numerator arrives left aligned, and only the requested number of steps run.
// ----------------------------------------------------------------------------
module ctd_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 17
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [NUM_W-1:0]             num,
   input  logic [DEN_W-1:0]             den,
   input  logic [$clog2(NUM_W+1)-1:0]   steps,
   output logic                         done,
   output logic [NUM_W-1:0]             quot
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DEN_W+1:0]  trial;

   // Trial subtraction of the divisor from the shifted partial remainder.
   assign trial = {1'b0, rem_ff, quo_ff[NUM_W-1]} - {2'b00, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DEN_W+1]) begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DEN_W-2:0], quo_ff[NUM_W-1]};
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ===== rtl/chirp_tone_with_decay_top.sv =====
// ----------------------------------------------------------------------------
// Chirp tone with decay
// Linear frequency sweep generator with a linear fade-out, one sample per
// tick request, built around one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
// A start request (opcode 0) loads the start and end frequency (hertz times
// 16), the segment length and the volume, and clears the phase; a start with
// a zero length is dropped. Each tick request (opcode 1) while a segment runs
// produces one response: a saturated signed 16-bit sample and a last flag on
// the final sample of the segment, after which the block is idle again. Ticks
// while idle produce nothing. The serial divider yields one quotient bit per
// cycle and runs three divisions per sample: the swept frequency, the phase
// increment and the envelope. req_stall stays high while a tick is in work.
// The response sits in its own register, so the next request is taken while
// a response is still stalled downstream. The sample rate register is written
// through the csr port, which is ready whenever no request is in work.
// ----------------------------------------------------------------------------
module chirp_tone_with_decay_top #(
   parameter int LENGTH_BITS     = ctd_pkg::LENGTH_BITS_DEF,
   parameter int PHASE_BITS      = ctd_pkg::PHASE_BITS_DEF,
   parameter int SINE_TABLE_BITS = ctd_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [ctd_pkg::FREQ_W-1:0]          req_start_freq,
   input  logic [ctd_pkg::FREQ_W-1:0]          req_end_freq,
   input  logic [ctd_pkg::LEN_W-1:0]           req_length,
   input  logic [ctd_pkg::VOL_W-1:0]           req_volume,
   // Response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ctd_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                                rsp_last,
   // Sample rate register write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ctd_pkg::RATE_W-1:0]          csr_sample_rate
);

   import ctd_pkg::*;

   // Numerator widths of the three divisions.
   localparam int FNUM_W = FREQ_W + LENGTH_BITS;
   localparam int INUM_W = FREQ_W + PHASE_BITS - FREQ_FRAC;
   localparam int ENUM_W = LENGTH_BITS + ENV_FRAC;
   localparam int NUM_FI = (FNUM_W > INUM_W) ? FNUM_W : INUM_W;
   localparam int NUM_W  = (NUM_FI > ENUM_W) ? NUM_FI : ENUM_W;
   localparam int DEN_W  = (LENGTH_BITS > RATE_W) ? LENGTH_BITS : RATE_W;
   localparam int STEP_W = $clog2(NUM_W + 1);

   // Shared multiplier and its product register.
   localparam int MUL_W  = 32;
   localparam int PROD_W = SCALE_SHIFT + SAMPLE_W;
   localparam int ACC_W  = (FNUM_W > MUL_W) ? FNUM_W : MUL_W;

   // Quarter-wave sine table, one entry more than a quarter so that the
   // mirrored index can reach the peak.
   localparam int QUARTER   = 2 ** (SINE_TABLE_BITS - 2);
   localparam int QDEPTH    = QUARTER + 1;
   localparam int QIDX_W    = SINE_TABLE_BITS - 1;
   localparam int TBL_SHIFT = 16 - SINE_TABLE_BITS;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_M1   = 4'd1;
   localparam logic [3:0] ST_M2   = 4'd2;
   localparam logic [3:0] ST_D1   = 4'd3;
   localparam logic [3:0] ST_W1   = 4'd4;
   localparam logic [3:0] ST_D2   = 4'd5;
   localparam logic [3:0] ST_W2   = 4'd6;
   localparam logic [3:0] ST_D3   = 4'd7;
   localparam logic [3:0] ST_W3   = 4'd8;
   localparam logic [3:0] ST_M3   = 4'd9;
   localparam logic [3:0] ST_M4   = 4'd10;
   localparam logic [3:0] ST_M5   = 4'd11;
   localparam logic [3:0] ST_OUT  = 4'd12;

   logic [3:0]                  state_ff, state_in;
   logic                        running_ff, running_in;
   logic [RATE_W-1:0]           rate_ff, rate_in;
   logic [FREQ_W-1:0]           start_ff, start_in;
   logic [FREQ_W-1:0]           end_ff, end_in;
   logic [VOL_W-1:0]            amp_ff, amp_in;
   logic [LENGTH_BITS-1:0]      len_ff, len_in;
   logic [LENGTH_BITS-1:0]      idx_ff, idx_in;
   logic [PHASE_BITS-1:0]       phase_ff, phase_in;
   logic [FREQ_W-1:0]           freq_ff, freq_in;
   logic [ENV_W-1:0]            env_ff, env_in;
   logic [SINE_MAG_W-1:0]       sine_mag_ff, sine_mag_in;
   logic                        sine_neg_ff, sine_neg_in;
   logic [ACC_W-1:0]            acc_ff, acc_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff, rsp_sample_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        req_accept;
   logic                        csr_write;
   logic                        rsp_free;
   logic [LENGTH_BITS-1:0]      req_len;
   logic [LENGTH_BITS-1:0]      remain;
   logic [LENGTH_BITS-1:0]      idx_next;
   logic                        is_last;
   logic [RATE_W-1:0]           rate_div;
   logic [FNUM_W-1:0]           freq_sum;

   logic [MUL_W-1:0]            mul_a;
   logic [MUL_W-1:0]            mul_b;
   logic [2*MUL_W-1:0]          mul_full;

   logic                        div_start;
   logic [NUM_W-1:0]            div_num;
   logic [DEN_W-1:0]            div_den;
   logic [STEP_W-1:0]           div_steps;
   logic                        div_done;
   logic [NUM_W-1:0]            div_quot;

   logic [1:0]                  quad;
   logic [SINE_TABLE_BITS-3:0]  qfrac;
   logic [QIDX_W-1:0]           qidx;
   logic [SINE_MAG_W-1:0]       qtab [QDEPTH];

   logic [SAMPLE_W-1:0]         mag;
   logic signed [SAMPLE_W-1:0]  sample_sat;

   // Handshakes. Requests are taken only between ticks; the response
   // register is separate, so a stalled response does not block a request.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign csr_write  = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign req_len  = LENGTH_BITS'(req_length);
   assign remain   = len_ff - idx_ff;
   assign idx_next = idx_ff + LENGTH_BITS'(1);
   assign is_last  = (idx_next == len_ff);

   // A zero sample rate divides as a rate of one.
   assign rate_div = (rate_ff == '0) ? RATE_W'(1) : rate_ff;

   // Weighted sum of the two sweep ends, the numerator of the frequency.
   assign freq_sum = FNUM_W'(acc_ff) + FNUM_W'(prod_ff);

   // The sine table holds the quarter wave, built at elaboration.
   for (genvar g = 0; g < QDEPTH; g++) begin : g_qtab
      assign qtab[g] = sine_quarter(longint'(g) << TBL_SHIFT);
   end

   // The top two phase bits pick the quadrant; odd quadrants read mirrored.
   assign quad  = phase_ff[PHASE_BITS-1 -: 2];
   assign qfrac = phase_ff[PHASE_BITS-3 -: (SINE_TABLE_BITS - 2)];
   assign qidx  = quad[0] ? (QIDX_W'(QUARTER) - QIDX_W'(qfrac)) : QIDX_W'(qfrac);

   // One 32 by 32 multiplier serves every product of a tick:
   // the two sweep weights, sine times envelope, volume times full scale,
   // and the final product of those two.
   always_comb begin
      case (state_ff)
         ST_M1: begin
            mul_a = MUL_W'(start_ff);
            mul_b = MUL_W'(remain);
         end
         ST_M2: begin
            mul_a = MUL_W'(end_ff);
            mul_b = MUL_W'(idx_ff);
         end
         ST_M3: begin
            mul_a = MUL_W'(env_ff);
            mul_b = MUL_W'(sine_mag_ff);
         end
         ST_M4: begin
            mul_a = MUL_W'(amp_ff);
            mul_b = MUL_W'(FULL_SCALE);
         end
         ST_M5: begin
            mul_a = acc_ff[MUL_W-1:0];
            mul_b = prod_ff[MUL_W-1:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;

   // Divider operands. Each numerator is left aligned so the divider only
   // runs as many steps as that numerator has bits.
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      div_steps = '0;
      case (state_ff)
         ST_D1: begin
            div_start = 1'b1;
            div_num   = NUM_W'(freq_sum) << (NUM_W - FNUM_W);
            div_den   = DEN_W'(len_ff);
            div_steps = STEP_W'(FNUM_W);
         end
         ST_D2: begin
            div_start = 1'b1;
            div_num   = NUM_W'({freq_ff, {(PHASE_BITS - FREQ_FRAC){1'b0}}})
                        << (NUM_W - INUM_W);
            div_den   = DEN_W'(rate_div);
            div_steps = STEP_W'(INUM_W);
         end
         ST_D3: begin
            div_start = 1'b1;
            div_num   = NUM_W'({remain, {ENV_FRAC{1'b0}}}) << (NUM_W - ENUM_W);
            div_den   = DEN_W'(len_ff);
            div_steps = STEP_W'(ENUM_W);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   ctd_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .steps (div_steps),
      .done  (div_done),
      .quot  (div_quot)
   );

   // The product is sine magnitude times envelope times volume times full
   // scale; its bits above the scale shift are the truncated magnitude.
   // The sign is applied after truncation, then the sample saturates.
   assign mag = prod_ff[SCALE_SHIFT +: SAMPLE_W];

   always_comb begin
      if (!sine_neg_ff) begin
         if (mag[SAMPLE_W-1]) begin
            sample_sat = SAMPLE_MAX;
         end else begin
            sample_sat = signed'(mag);
         end
      end else begin
         if (mag[SAMPLE_W-1] && (mag[SAMPLE_W-2:0] != '0)) begin
            sample_sat = SAMPLE_MIN;
         end else begin
            sample_sat = signed'(SAMPLE_W'(~mag + SAMPLE_W'(1)));
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      running_in    = running_ff;
      rate_in       = rate_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      amp_in        = amp_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      phase_in      = phase_ff;
      freq_in       = freq_ff;
      env_in        = env_ff;
      sine_mag_in   = sine_mag_ff;
      sine_neg_in   = sine_neg_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         rate_in = csr_sample_rate;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_opcode == OP_START) begin
                  // A new segment replaces any segment in progress.
                  if (req_len != '0) begin
                     start_in   = req_start_freq;
                     end_in     = req_end_freq;
                     amp_in     = req_volume;
                     len_in     = req_len;
                     idx_in     = '0;
                     phase_in   = '0;
                     running_in = 1'b1;
                  end
               end else if ((req_opcode == OP_TICK) && running_ff) begin
                  state_in = ST_M1;
               end
            end
         end
         ST_M1: begin
            prod_in  = mul_full[PROD_W-1:0];
            state_in = ST_M2;
         end
         ST_M2: begin
            acc_in   = ACC_W'(prod_ff);
            prod_in  = mul_full[PROD_W-1:0];
            state_in = ST_D1;
         end
         ST_D1: begin
            state_in = ST_W1;
         end
         ST_W1: begin
            if (div_done) begin
               freq_in  = div_quot[FREQ_W-1:0];
               state_in = ST_D2;
            end
         end
         ST_D2: begin
            state_in = ST_W2;
         end
         ST_W2: begin
            if (div_done) begin
               // The increment keeps only a whole turn, so it wraps.
               phase_in = phase_ff + div_quot[PHASE_BITS-1:0];
               state_in = ST_D3;
            end
         end
         ST_D3: begin
            sine_mag_in = qtab[qidx];
            sine_neg_in = quad[1];
            state_in    = ST_W3;
         end
         ST_W3: begin
            if (div_done) begin
               env_in   = div_quot[ENV_W-1:0];
               state_in = ST_M3;
            end
         end
         ST_M3: begin
            prod_in  = mul_full[PROD_W-1:0];
            state_in = ST_M4;
         end
         ST_M4: begin
            acc_in   = ACC_W'(prod_ff);
            prod_in  = mul_full[PROD_W-1:0];
            state_in = ST_M5;
         end
         ST_M5: begin
            prod_in  = mul_full[PROD_W-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hold here until the response register has room.
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sample_sat;
               rsp_last_in   = is_last;
               idx_in        = idx_next;
               if (is_last) begin
                  running_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff      <= start_in;
      end_ff        <= end_in;
      amp_ff        <= amp_in;
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      phase_ff      <= phase_in;
      freq_ff       <= freq_in;
      env_ff        <= env_in;
      sine_mag_ff   <= sine_mag_in;
      sine_neg_ff   <= sine_neg_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         rate_ff      <= RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

   // While a segment runs, the next sample index lies inside the segment.
   a_idx_in_segment: assert property (@(posedge clock) disable iff (reset)
      running_ff |-> (idx_ff < len_ff))
      else $error("sample index beyond segment length while running");

   // Delivering the final sample of a segment ends the segment.
   a_last_ends_segment: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_OUT) && rsp_free && is_last) |=> !running_ff)
      else $error("segment still running after its final sample");

   // The divider only finishes while the sequencer waits for it.
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ((state_ff == ST_W1) || (state_ff == ST_W2) ||
                    (state_ff == ST_W3)))
      else $error("divider finished outside a wait state");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chirp tone with decay testbench
// Drives start and tick requests into the sweep generator, predicts every PCM
// sample with a bit-exact integer model of the sweep, phase and fade-out, and
// checks each response in order under changing sample rates and flow control.
// ----------------------------------------------------------------------------
module testbench;
   import ctd_pkg::*;

   // Predictor widths follow the default build of the block.
   localparam int              PH_BITS   = PHASE_BITS_DEF;
   localparam int              TBL_BITS  = SINE_TABLE_BITS_DEF;
   localparam longint unsigned PH_MASK   = (64'd1 << PH_BITS) - 64'd1;
   localparam longint unsigned POS_MASK  = (64'd1 << LENGTH_BITS_DEF) - 64'd1;
   localparam longint          Q30_ONE   = 64'sd1073741824;
   localparam longint          Q29_ONE   = 64'sd536870912;
   localparam longint          OUT_SHIFT = 64'sd1 <<< SCALE_SHIFT;
   localparam int              FREQ_TOP  = (1 << FREQ_W) - 1;

   // This covers a whole tick in work with margin before any register write
   // and before the verdict.
   localparam int SETTLE_CYCLES = 160;
   // Cycles without any handshake before the run is declared hung. The longest
   // legal quiet stretch is the deliberate receiver hold-off.
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_OFF_LEN  = 600;

   typedef struct {
      logic              opcode;
      logic [FREQ_W-1:0] start_freq;
      logic [FREQ_W-1:0] end_freq;
      logic [LEN_W-1:0]  length;
      logic [VOL_W-1:0]  volume;
   } tone_req_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] pcm;
      logic                       is_last;
   } tone_sample_type;

   // ------------------------------------------------------------------------
   // Block connections. Every input starts at a known value.
   // ------------------------------------------------------------------------
   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_opcode = OP_TICK;
   logic [FREQ_W-1:0]           req_start_freq = '0;
   logic [FREQ_W-1:0]           req_end_freq = '0;
   logic [LEN_W-1:0]            req_length = '0;
   logic [VOL_W-1:0]            req_volume = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0]  rsp_sample;
   logic                        rsp_last;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [RATE_W-1:0]           csr_sample_rate = RATE_RESET;

   chirp_tone_with_decay_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_start_freq  (req_start_freq),
      .req_end_freq    (req_end_freq),
      .req_length      (req_length),
      .req_volume      (req_volume),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_sample_rate (csr_sample_rate)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor state: a private copy of the generator's registers.
   // ------------------------------------------------------------------------
   logic [RATE_W-1:0]  tone_rate = RATE_RESET;
   longint unsigned    tone_phase = 0;
   longint unsigned    tone_pos = 0;
   longint unsigned    tone_len = 0;
   logic [FREQ_W-1:0]  tone_f_start = '0;
   logic [FREQ_W-1:0]  tone_f_end = '0;
   logic [VOL_W-1:0]   tone_volume = '0;
   bit                 tone_running = 1'b0;

   tone_sample_type expected_samples[$];

   // Flow control knobs, set per phase by the tests.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_off_order = 0;

   // Bookkeeping for the summary and the verdict.
   int mismatches = 0;
   int effective_requests = 0;
   int samples_seen = 0;
   int last_flags_seen = 0;
   int saturated_predicted = 0;
   int rate_writes = 0;
   int quiet_cycles = 0;

   function automatic bit chance(input int pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   // Quarter-wave polynomial sine, Q1.15, addressed by the top table bits of
   // the phase. The second half of the turn mirrors the first with a sign flip.
   function automatic longint sine_q15(input longint unsigned ph);
      longint unsigned addr, u, quad, r;
      longint x, x2, p, y;
      addr = (ph & PH_MASK) >> (PH_BITS - TBL_BITS);
      u    = (addr << (16 - TBL_BITS)) & 64'hFFFF;
      quad = u >> 14;
      r    = u & 64'h3FFF;
      if (quad[0]) begin
         r = 64'd16384 - r;
      end
      x  = longint'(r);
      x2 = (x * x) * 4;
      p  = 64'sd172272;
      p  = -64'sd5026995 + (p * x2) / Q30_ONE;
      p  = 64'sd85569306 + (p * x2) / Q30_ONE;
      p  = -64'sd693598669 + (p * x2) / Q30_ONE;
      p  = 64'sd1686629713 + (p * x2) / Q30_ONE;
      y  = (p * x) / Q29_ONE;
      if (y > 64'sd32767) begin
         y = 64'sd32767;
      end
      if (y < 64'sd0) begin
         y = 64'sd0;
      end
      return quad[1] ? -y : y;
   endfunction

   // Advances the private model by one accepted request and queues the sample
   // it must produce. Returns 1 when the request had any effect at all, so
   // that ignored requests do not count toward the stimulus budget.
   function automatic bit predict_tone(input tone_req_type r);
      longint unsigned n, i, freq, rate, inc, env;
      longint          sine, val;
      tone_sample_type e;
      if (r.opcode == OP_START) begin
         // A zero length start leaves everything as it was, even mid-segment.
         if (r.length == '0) begin
            return 1'b0;
         end
         tone_f_start = r.start_freq;
         tone_f_end   = r.end_freq;
         tone_volume  = r.volume;
         tone_len     = r.length;
         tone_pos     = 0;
         tone_phase   = 0;
         tone_running = 1'b1;
         return 1'b1;
      end
      if (!tone_running || tone_len == 0) begin
         return 1'b0;
      end
      n = tone_len;
      i = (tone_pos >= n) ? n - 1 : tone_pos;
      // Linear sweep, then the per-sample phase step as a fraction of a turn.
      freq = (tone_f_start * (n - i) + tone_f_end * i) / n;
      rate = (tone_rate == '0) ? 64'd1 : 64'(tone_rate);
      inc  = ((freq << PH_BITS) / (64'd16 * rate)) & PH_MASK;
      tone_phase = (tone_phase + inc) & PH_MASK;
      sine = sine_q15(tone_phase);
      // Linear fade-out envelope as a 16-bit fraction that starts at one.
      env = ((n - i) << 16) / n;
      val = (sine * longint'(env) * longint'(64'(tone_volume)) * 64'sd32000) / OUT_SHIFT;
      if (val > 64'sd32767) begin
         val = 64'sd32767;
         saturated_predicted++;
      end else if (val < -64'sd32768) begin
         val = -64'sd32768;
         saturated_predicted++;
      end
      e.pcm     = SAMPLE_W'(val);
      e.is_last = (i + 1 == n);
      expected_samples = {expected_samples, e};
      tone_pos = (i + 1) & POS_MASK;
      if (e.is_last) begin
         tone_running = 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   // ------------------------------------------------------------------------
   // Request sender. Valid is never lowered at the acceptance edge, so the
   // next request can follow back to back; an idle gap lowers it instead.
   // ------------------------------------------------------------------------
   task automatic send_request(input tone_req_type r);
      while (chance(send_idle_pct)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= r.opcode;
      req_start_freq <= r.start_freq;
      req_end_freq   <= r.end_freq;
      req_length     <= r.length;
      req_volume     <= r.volume;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      if (predict_tone(r)) begin
         effective_requests++;
      end
   endtask

   // Lowers valid, waits for every predicted sample, then lets a possible idle
   // tick finish inside the block so that the register may be written safely.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sample_rate(input logic [RATE_W-1:0] rate);
      csr_valid       <= 1'b1;
      csr_sample_rate <= rate;
      do begin
         @(posedge clock);
      end while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      tone_rate = rate;
      rate_writes++;
   endtask

   // Random request fields: frequencies over the full port width, lengths from 1
   // to 40. Ticks carry random junk in the fields the block must ignore.
   function automatic tone_req_type random_request(input logic op);
      tone_req_type r;
      r.opcode     = op;
      r.start_freq = FREQ_W'($urandom_range(FREQ_TOP, 0));
      r.end_freq   = chance(25) ? r.start_freq : FREQ_W'($urandom_range(FREQ_TOP, 0));
      r.length     = chance(15) ? LEN_W'($urandom_range(40, 13)) : LEN_W'($urandom_range(12, 1));
      r.volume     = chance(10) ? VOL_W'($urandom) : VOL_W'($urandom_range(32768, 0));
      return r;
   endfunction

   function automatic tone_req_type make_start(input int f0, input int f1, input int len,
                                               input int vol);
      tone_req_type r;
      r.opcode     = OP_START;
      r.start_freq = FREQ_W'(f0);
      r.end_freq   = FREQ_W'(f1);
      r.length     = LEN_W'(len);
      r.volume     = VOL_W'(vol);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Response checker: every accepted sample is matched against the oldest
   // prediction. Outputs are read right after the edge, before any update.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      tone_sample_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         samples_seen++;
         if (rsp_last === 1'b1) begin
            last_flags_seen++;
         end
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending (sample %0d last %b)",
                                      rsp_sample, rsp_last));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample !== want.pcm) begin
               report_mismatch($sformatf("sample %0d: expected %0d, got %0d",
                                         samples_seen, want.pcm, rsp_sample));
            end
            if (rsp_last !== want.is_last) begin
               report_mismatch($sformatf("sample %0d: expected last %b, got %b",
                                         samples_seen, want.is_last, rsp_last));
            end
         end
      end
   end

   // Receiver flow control. A hold-off order from a test keeps the output
   // stalled for a long counted stretch; otherwise stall is drawn at random.
   always @(posedge clock) begin
      static int hold_left = 0;
      if (hold_off_order > 0) begin
         hold_left      = hold_off_order;
         hold_off_order = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= chance(rsp_stall_pct);
      end
   end

   // Watchdog: any handshake on any channel proves progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no handshake for %0d cycles, %0d samples still pending",
                  QUIET_LIMIT, expected_samples.size());
         $display("[chirp_tone_with_decay_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Ticks while idle and a zero length start must produce nothing.
   task automatic test_idle_requests();
      send_request(random_request(OP_TICK));
      send_request(make_start(16000, 32000, 0, 32768));
      send_request(random_request(OP_TICK));
   endtask

   // Field extremes: widest frequencies with the loudest volume, silence at
   // zero frequency, and a rising sweep from zero.
   task automatic test_field_extremes();
      send_request(make_start(FREQ_TOP, FREQ_TOP, 1, 16'hFFFF));
      send_request(random_request(OP_TICK));
      send_request(make_start(0, 0, 2, 32768));
      repeat (2) send_request(random_request(OP_TICK));
      send_request(make_start(0, FREQ_TOP, 3, 32768));
      repeat (3) send_request(random_request(OP_TICK));
   endtask

   // A new start replaces a running segment at once, a zero length start in
   // the middle of a segment changes nothing, and a tick after the last
   // sample is dropped.
   task automatic test_restart_while_running();
      send_request(make_start(768000, 0, 65535, 32768));
      repeat (2) send_request(random_request(OP_TICK));
      send_request(make_start(123, 456, 0, 1));
      send_request(random_request(OP_TICK));
      send_request(make_start(16000, 16000, 2, 20000));
      repeat (3) send_request(random_request(OP_TICK));
   endtask

   // Sample rate extremes, including zero (taken as one) and the largest
   // value the register holds, each with a short high-pitched segment.
   task automatic test_sample_rates();
      int rates[4] = '{8000, 96000, 0, (1 << RATE_W) - 1};
      foreach (rates[k]) begin
         settle_block();
         write_sample_rate(RATE_W'(rates[k]));
         send_request(make_start(768000, FREQ_TOP, 2, 32768));
         repeat (2) send_request(random_request(OP_TICK));
      end
   endtask

   // Mostly complete segments with random content; the rest are long
   // segments cut short by the next start, stray ticks and zero length starts.
   task automatic run_random_phase(input int budget, input int idle_pct, input int stall_pct);
      int           goal;
      int           kind;
      int           ticks;
      tone_req_type r;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      goal = effective_requests + budget;
      while (effective_requests < goal) begin
         kind = $urandom_range(99, 0);
         r    = random_request(OP_START);
         if (kind < 4) begin
            r.length = '0;
            send_request(r);
         end else if (kind < 10) begin
            send_request(random_request(OP_TICK));
         end else begin
            if (kind < 16) begin
               r.length = LEN_W'($urandom_range(65535, 1));
               ticks    = $urandom_range(6, 1);
            end else begin
               ticks = int'(r.length);
               if (chance(10)) begin
                  ticks = $urandom_range(int'(r.length) - 1, 0);
               end else if (chance(10)) begin
                  ticks++;
               end
            end
            send_request(r);
            repeat (ticks) send_request(random_request(OP_TICK));
         end
      end
   endtask

   // Four flow-control modes, each at a fresh random rate in the audio range.
   task automatic test_random_traffic();
      int idle_mix[4]  = '{0, 55, 0, 7};
      int stall_mix[4] = '{0, 0, 55, 7};
      foreach (idle_mix[k]) begin
         settle_block();
         write_sample_rate(RATE_W'($urandom_range(96000, 8000)));
         run_random_phase(500, idle_mix[k], stall_mix[k]);
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // The receiver holds off for a long stretch while ticks keep coming, so
   // the output register and the working tick both fill and req_stall rises.
   task automatic test_output_backpressure();
      settle_block();
      write_sample_rate(RATE_RESET);
      hold_off_order = HOLD_OFF_LEN;
      send_request(make_start(7040, 14080, 8, 32768));
      repeat (8) send_request(random_request(OP_TICK));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_idle_requests();
      test_field_extremes();
      test_restart_while_running();
      test_sample_rates();
      test_random_traffic();
      test_output_backpressure();

      settle_block();
      if (expected_samples.size() != 0) begin
         report_mismatch($sformatf("%0d samples never arrived", expected_samples.size()));
      end
      $display("covered %0d effective requests, %0d samples (%0d segment ends),",
               effective_requests, samples_seen, last_flags_seen);
      $display("%0d saturated samples, %0d sample rate writes, %0d mismatches",
               saturated_predicted, rate_writes, mismatches);
      if (mismatches == 0) begin
         $display("[chirp_tone_with_decay_top] OK");
      end else begin
         $display("[chirp_tone_with_decay_top] ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ctd_pkg.sv
rtl/ctd_div.sv
rtl/chirp_tone_with_decay_top.sv
sim/testbench.sv
